[hw/rtl/pit_pkg.sv]
package pit_pkg;

  // coordinate format
  localparam int COORD_W = 16;

  // length path: L = floor(sqrt((dx^2 + dy^2) << LEN_SHIFT))
  localparam int SQ_W      = 2 * COORD_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int LEN_SHIFT = 64;
  localparam int LEN_W     = 49;
  localparam int LEN_RAD_W = 2 * LEN_W;

  // Heron path: four factors, product, root
  localparam int SUM2_W     = LEN_W + 1;
  localparam int TERM_W     = LEN_W + 2;
  localparam int DIG_W      = 8;
  localparam int MUL_DIGITS = (TERM_W + DIG_W - 1) / DIG_W;
  localparam int MUL_Y_W    = MUL_DIGITS * DIG_W;
  localparam int MUL_OPS    = 3;
  localparam int MUL_STAGES = MUL_OPS * MUL_DIGITS;
  localparam int MUL_X_W    = 3 * TERM_W;
  localparam int MUL_PP_W   = MUL_X_W + DIG_W;
  localparam int QUEUE_W    = 2 * TERM_W;
  localparam int PROD_W     = 4 * TERM_W;
  localparam int AREA_W     = PROD_W / 2;

  // final compare
  localparam int SUM_W     = AREA_W + 2;
  localparam int TOL_W     = 16;
  localparam int TOL_SHIFT = 66;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

endpackage

[hw/rtl/pit_len.sv]
module pit_len
  import pit_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [COORD_W-1:0] x0,
  input  logic [COORD_W-1:0] y0,
  input  logic [COORD_W-1:0] x1,
  input  logic [COORD_W-1:0] y1,
  output logic               out_valid,
  output logic [LEN_W-1:0]   len
);

  logic [COORD_W:0]   dxs, dys;
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    dx2, dy2;
  logic               v1, v2;

  logic [LEN_RAD_W-1:0] rem  [LEN_W+1];
  logic [LEN_W-1:0]     root [LEN_W+1];
  logic                 vld  [LEN_W+1];

  assign dxs = {x0[COORD_W-1], x0} - {x1[COORD_W-1], x1};
  assign dys = {y0[COORD_W-1], y0} - {y1[COORD_W-1], y1};

  always_ff @(posedge clk) begin
    dx  <= dxs[COORD_W] ? COORD_W'(-dxs) : dxs[COORD_W-1:0];
    dy  <= dys[COORD_W] ? COORD_W'(-dys) : dys[COORD_W-1:0];
    dx2 <= SQ_W'(dx) * SQ_W'(dx);
    dy2 <= SQ_W'(dy) * SQ_W'(dy);
    rem[0]  <= LEN_RAD_W'({(D2_W'(dx2) + D2_W'(dy2)), {LEN_SHIFT{1'b0}}});
    root[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      vld[0] <= 1'b0;
    end else begin
      v1     <= in_valid;
      v2     <= v1;
      vld[0] <= v2;
    end
  end

  // restoring square root, one root bit per stage, MSB first
  for (genvar s = 0; s < LEN_W; s++) begin : g_sqrt
    localparam int B = LEN_W - 1 - s;
    logic [LEN_RAD_W-1:0] trial;
    logic                 take;

    assign trial = (LEN_RAD_W'(root[s]) << (B + 1)) | (LEN_RAD_W'(1) << (2 * B));
    assign take  = rem[s] >= trial;

    always_ff @(posedge clk) begin
      rem[s+1]  <= take ? rem[s] - trial : rem[s];
      root[s+1] <= take ? root[s] | (LEN_W'(1) << B) : root[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
  end

  assign len       = root[LEN_W];
  assign out_valid = vld[LEN_W];

endmodule

[hw/rtl/pit_area.sv]
module pit_area
  import pit_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [LEN_W-1:0]  a,
  input  logic [LEN_W-1:0]  b,
  input  logic [LEN_W-1:0]  c,
  output logic              out_valid,
  output logic [AREA_W-1:0] area
);

  logic [LEN_W-1:0]  a_r, b_r, c_r;
  logic [SUM2_W-1:0] ab, bc, ac;
  logic              flat;
  logic              v1;

  // multiply chain: acc += x * digit(y) << (DIG_W * k)
  logic [PROD_W-1:0]  acc [MUL_STAGES+1];
  logic [MUL_X_W-1:0] mx  [MUL_STAGES+1];
  logic [MUL_Y_W-1:0] my  [MUL_STAGES+1];
  logic [QUEUE_W-1:0] mq  [MUL_STAGES+1];
  logic               mv  [MUL_STAGES+1];

  logic [PROD_W-1:0] rem  [AREA_W+1];
  logic [AREA_W-1:0] root [AREA_W+1];
  logic              vld  [AREA_W+1];

  assign flat = (bc <= SUM2_W'(a_r)) || (ac <= SUM2_W'(b_r)) || (ab <= SUM2_W'(c_r));

  always_ff @(posedge clk) begin
    a_r <= a;
    b_r <= b;
    c_r <= c;
    ab  <= SUM2_W'(a) + SUM2_W'(b);
    bc  <= SUM2_W'(b) + SUM2_W'(c);
    ac  <= SUM2_W'(a) + SUM2_W'(c);
    // a flat or degenerate triangle zeroes the product
    acc[0] <= '0;
    mx[0]  <= flat ? '0 : MUL_X_W'(TERM_W'(ab) + TERM_W'(c_r));
    my[0]  <= MUL_Y_W'(TERM_W'(bc - SUM2_W'(a_r)));
    mq[0]  <= {TERM_W'(ac - SUM2_W'(b_r)), TERM_W'(ab - SUM2_W'(c_r))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      mv[0] <= 1'b0;
    end else begin
      v1    <= in_valid;
      mv[0] <= v1;
    end
  end

  for (genvar j = 0; j < MUL_STAGES; j++) begin : g_mul
    localparam int K = j % MUL_DIGITS;
    localparam int M = j / MUL_DIGITS;
    logic [MUL_PP_W-1:0] pp;
    logic [PROD_W-1:0]   sum;

    assign pp  = MUL_PP_W'(mx[j]) * MUL_PP_W'(my[j][DIG_W-1:0]);
    assign sum = acc[j] + (PROD_W'(pp) << (DIG_W * K));

    if (K == MUL_DIGITS - 1 && M < MUL_OPS - 1) begin : g_next
      // product done: it becomes the next multiplicand
      always_ff @(posedge clk) begin
        acc[j+1] <= '0;
        mx[j+1]  <= sum[MUL_X_W-1:0];
        my[j+1]  <= MUL_Y_W'(mq[j][QUEUE_W-1 -: TERM_W]);
        mq[j+1]  <= mq[j] << TERM_W;
      end
    end else begin : g_step
      always_ff @(posedge clk) begin
        acc[j+1] <= sum;
        mx[j+1]  <= mx[j];
        my[j+1]  <= my[j] >> DIG_W;
        mq[j+1]  <= mq[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mv[j+1] <= 1'b0;
      end else begin
        mv[j+1] <= mv[j];
      end
    end
  end

  assign rem[0]  = acc[MUL_STAGES];
  assign root[0] = '0;
  assign vld[0]  = mv[MUL_STAGES];

  for (genvar s = 0; s < AREA_W; s++) begin : g_sqrt
    localparam int B = AREA_W - 1 - s;
    logic [PROD_W-1:0] trial;
    logic              take;

    assign trial = (PROD_W'(root[s]) << (B + 1)) | (PROD_W'(1) << (2 * B));
    assign take  = rem[s] >= trial;

    always_ff @(posedge clk) begin
      rem[s+1]  <= take ? rem[s] - trial : rem[s];
      root[s+1] <= take ? root[s] | (AREA_W'(1) << B) : root[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
  end

  assign area      = root[AREA_W];
  assign out_valid = vld[AREA_W];

endmodule

[hw/rtl/point_in_triangle_area_test.sv]
// Point-in-triangle test by Heron areas.
// Input: start with point_x/y and corner_a/b/c_x/y (signed Q8.8) is taken on
//   every clock edge where start is high; busy is tied low, so an item can
//   enter every cycle.
// Output: done pulses for one cycle with inside_res (1 = in or on the
//   triangle). The receiver cannot stall; results leave in input order.
// Config: cfg_wr_en/cfg_wr_data write area_tolerance (2^-16 square units)
//   at the clock edge; only write it while no item is in flight.
// Throughput: one item per cycle. Pipeline: 3 stages of differences and
//   squares, a 49-stage length square root, 2 stages of Heron factors, a
//   21-stage multiply chain (8 bits of multiplier per stage), a 102-stage
//   area square root, and 2 stages of sum and compare.
// Reset: synchronous rst clears all valid bits and sets area_tolerance to 66.
module point_in_triangle_area_test
  import pit_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] point_x,
  input  logic [COORD_W-1:0] point_y,
  input  logic [COORD_W-1:0] corner_a_x,
  input  logic [COORD_W-1:0] corner_a_y,
  input  logic [COORD_W-1:0] corner_b_x,
  input  logic [COORD_W-1:0] corner_b_y,
  input  logic [COORD_W-1:0] corner_c_x,
  input  logic [COORD_W-1:0] corner_c_y,
  input  logic               cfg_wr_en,
  input  logic [TOL_W-1:0]   cfg_wr_data,
  output logic               done,
  output logic               inside_res
);

  logic [TOL_W-1:0] area_tolerance;

  // six side lengths: AB, BC, CA, PA, PB, PC
  logic [5:0]       lv;
  logic [LEN_W-1:0] l_ab, l_bc, l_ca, l_pa, l_pb, l_pc;
  logic             len_valid;

  // four areas: ABC, PAB, PBC, PCA
  logic [3:0]        av;
  logic [AREA_W-1:0] q_whole, q_pab, q_pbc, q_pca;
  logic              area_valid;

  logic [SUM_W-1:0] parts, limit;
  logic             sum_valid;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_tolerance <= TOL_RESET;
    end else if (cfg_wr_en) begin
      area_tolerance <= cfg_wr_data;
    end
  end

  pit_len u_len_ab (.clk, .rst, .in_valid(start),
    .x0(corner_a_x), .y0(corner_a_y), .x1(corner_b_x), .y1(corner_b_y),
    .out_valid(lv[0]), .len(l_ab));
  pit_len u_len_bc (.clk, .rst, .in_valid(start),
    .x0(corner_b_x), .y0(corner_b_y), .x1(corner_c_x), .y1(corner_c_y),
    .out_valid(lv[1]), .len(l_bc));
  pit_len u_len_ca (.clk, .rst, .in_valid(start),
    .x0(corner_c_x), .y0(corner_c_y), .x1(corner_a_x), .y1(corner_a_y),
    .out_valid(lv[2]), .len(l_ca));
  pit_len u_len_pa (.clk, .rst, .in_valid(start),
    .x0(point_x), .y0(point_y), .x1(corner_a_x), .y1(corner_a_y),
    .out_valid(lv[3]), .len(l_pa));
  pit_len u_len_pb (.clk, .rst, .in_valid(start),
    .x0(point_x), .y0(point_y), .x1(corner_b_x), .y1(corner_b_y),
    .out_valid(lv[4]), .len(l_pb));
  pit_len u_len_pc (.clk, .rst, .in_valid(start),
    .x0(point_x), .y0(point_y), .x1(corner_c_x), .y1(corner_c_y),
    .out_valid(lv[5]), .len(l_pc));

  // all length units run in lockstep
  assign len_valid = &lv;

  pit_area u_area_abc (.clk, .rst, .in_valid(len_valid),
    .a(l_ab), .b(l_bc), .c(l_ca), .out_valid(av[0]), .area(q_whole));
  pit_area u_area_pab (.clk, .rst, .in_valid(len_valid),
    .a(l_pa), .b(l_pb), .c(l_ab), .out_valid(av[1]), .area(q_pab));
  pit_area u_area_pbc (.clk, .rst, .in_valid(len_valid),
    .a(l_pb), .b(l_pc), .c(l_bc), .out_valid(av[2]), .area(q_pbc));
  pit_area u_area_pca (.clk, .rst, .in_valid(len_valid),
    .a(l_pc), .b(l_pa), .c(l_ca), .out_valid(av[3]), .area(q_pca));

  assign area_valid = &av;

  // sum of sub-areas vs whole area plus tolerance (scaled to 2^-82 square units)
  always_ff @(posedge clk) begin
    parts <= SUM_W'(q_pab) + SUM_W'(q_pbc) + SUM_W'(q_pca);
    limit <= SUM_W'(q_whole) + (SUM_W'(area_tolerance) << TOL_SHIFT);
    inside_res <= parts <= limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      sum_valid <= area_valid;
      done      <= sum_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_lockstep: assert property (@(posedge clk) disable iff (rst)
    (&lv) == (|lv))
    else $error("length units out of step");

  a_area_lockstep: assert property (@(posedge clk) disable iff (rst)
    (&av) == (|av))
    else $error("area units out of step");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(sum_valid))
    else $error("result without a pending item");

  a_sum_follows: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> $past(area_valid))
    else $error("sum stage loaded without area results");
`endif

endmodule

[sim/point_in_triangle_area_test_tb.sv]
`timescale 1ns / 1ps

module point_in_triangle_area_test_tb;
  import pit_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 200;   // more than the pipeline latency
  localparam int ITEMS_PER_PASS = 350;

  // one query: point and the three corners, plus a flag that makes the
  // driver hold it back until every pending answer has come out
  typedef struct packed {
    logic signed [COORD_W-1:0] px, py, ax, ay, bx, by, cx, cy;
    logic                      drain_first;
  } query_t;

  logic clk, rst, start, busy, done, inside_res;
  logic [COORD_W-1:0] point_x, point_y, corner_a_x, corner_a_y;
  logic [COORD_W-1:0] corner_b_x, corner_b_y, corner_c_x, corner_c_y;
  logic               cfg_wr_en;
  logic [TOL_W-1:0]   cfg_wr_data;

  query_t     pending_q[$];     // items waiting to be driven
  logic       inside_q[$];      // predicted answers, oldest first
  query_t     in_flight;        // item currently on the input ports
  logic [TOL_W-1:0] tol_shadow; // our copy of area_tolerance
  int         n_errors, n_accepted, idle_cnt;
  bit         launch, calm;

  point_in_triangle_area_test u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y),
    .corner_a_x(corner_a_x), .corner_a_y(corner_a_y),
    .corner_b_x(corner_b_x), .corner_b_y(corner_b_y),
    .corner_c_x(corner_c_x), .corner_c_y(corner_c_y),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .done(done), .inside_res(inside_res)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // ---------------------------------------------------------------
  // Exact predictor. Everything is carried in 256-bit unsigned math:
  // lengths are < 2^49, Heron products < 2^204, roots < 2^102.
  // ---------------------------------------------------------------
  function automatic logic [255:0] int_sqrt(input logic [255:0] n);
    logic [255:0] r, c;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // side length, scaled by 2^32 so rounding stays far below one LSB
  function automatic logic [255:0] side_len(input logic signed [COORD_W-1:0] x0, y0, x1, y1);
    logic signed [COORD_W+1:0] dx, dy;
    logic [255:0] ux, uy;
    dx = x0 - x1;
    dy = y0 - y1;
    ux = (dx < 0) ? 256'(-dx) : 256'(dx);
    uy = (dy < 0) ? 256'(-dy) : 256'(dy);
    return int_sqrt((ux * ux + uy * uy) << LEN_SHIFT);
  endfunction

  // four times the area from the sides; degenerate or rounded-flat gives 0
  function automatic logic [255:0] heron4(input logic [255:0] a, b, c);
    if (b + c <= a || a + c <= b || a + b <= c) return '0;
    return int_sqrt((a + b + c) * (b + c - a) * (a + c - b) * (a + b - c));
  endfunction

  function automatic logic predict_inside(input query_t q, input logic [TOL_W-1:0] tol);
    logic [255:0] ab, bc, ca, pa, pb, pc, whole, parts, limit;
    ab = side_len(q.ax, q.ay, q.bx, q.by);
    bc = side_len(q.bx, q.by, q.cx, q.cy);
    ca = side_len(q.cx, q.cy, q.ax, q.ay);
    pa = side_len(q.px, q.py, q.ax, q.ay);
    pb = side_len(q.px, q.py, q.bx, q.by);
    pc = side_len(q.px, q.py, q.cx, q.cy);
    whole = heron4(ab, bc, ca);
    parts = heron4(pa, pb, ab) + heron4(pb, pc, bc) + heron4(pc, pa, ca);
    limit = whole + (256'(tol) << TOL_SHIFT);
    return parts <= limit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------
  // Driver: one NBA per signal per edge. On acceptance the answer is
  // predicted with the tolerance in force right now (writes only
  // happen while the pipe is empty, so this is safe).
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        inside_q.push_back(predict_inside(in_flight, tol_shadow));
        n_accepted++;
      end
      if (start && busy) begin
        launch = 1'b1;  // keep offering the same item
      end else begin
        // ~33% idle, except for a long back-to-back stretch mid-run
        calm   = (n_accepted >= 700 && n_accepted < 1000);
        launch = pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33);
        // drain-first item waits for every pending answer
        if (launch && pending_q[0].drain_first && inside_q.size() != 0) launch = 1'b0;
        if (launch) begin
          in_flight  = pending_q.pop_front();
          point_x    <= in_flight.px;
          point_y    <= in_flight.py;
          corner_a_x <= in_flight.ax;
          corner_a_y <= in_flight.ay;
          corner_b_x <= in_flight.bx;
          corner_b_y <= in_flight.by;
          corner_c_x <= in_flight.cx;
          corner_c_y <= in_flight.cy;
        end
      end
      start <= launch;
    end
  end

  // Monitor: done is a one-cycle strobe, sampled at the edge ending it.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (inside_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result inside_res=%0b", inside_res));
      end else begin
        logic want;
        want = inside_q.pop_front();
        if (inside_res !== want)
          report_mismatch($sformatf("inside_res got %b want %b", inside_res, want));
      end
    end
  end

  // Watchdog: cycles with no item taken and no result seen.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("point_in_triangle_area_test regression: fail");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic query_t mk(input int px, py, ax, ay, bx, by, cx, cy);
    query_t q;
    q.px = COORD_W'(px); q.py = COORD_W'(py);
    q.ax = COORD_W'(ax); q.ay = COORD_W'(ay);
    q.bx = COORD_W'(bx); q.by = COORD_W'(by);
    q.cx = COORD_W'(cx); q.cy = COORD_W'(cy);
    q.drain_first = 1'b0;
    return q;
  endfunction

  // Random query. Most are small well-formed triangles with the point
  // placed inside, on an edge, just off it or at random nearby; the rest is raw noise
  // over the full coordinate range (covers every bit).
  function automatic query_t random_query();
    query_t q;
    int ox, oy, w1, w2, w3, ws, kind;
    int ax, ay, bx, by, cx, cy;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      q = {$urandom, $urandom, $urandom, $urandom, 1'b0};
      return q;
    end
    ox = $urandom_range(0, 40000) - 20000;
    oy = $urandom_range(0, 40000) - 20000;
    ax = ox + $urandom_range(0, 6000) - 3000;
    ay = oy + $urandom_range(0, 6000) - 3000;
    bx = ox + $urandom_range(0, 6000) - 3000;
    by = oy + $urandom_range(0, 6000) - 3000;
    cx = ox + $urandom_range(0, 6000) - 3000;
    cy = oy + $urandom_range(0, 6000) - 3000;
    if (kind < 70) begin
      // convex combination: inside (up to rounding)
      w1 = $urandom_range(0, 100);
      w2 = $urandom_range(0, 100);
      w3 = $urandom_range(1, 100);
      ws = w1 + w2 + w3;
      q = mk((ax * w1 + bx * w2 + cx * w3) / ws, (ay * w1 + by * w2 + cy * w3) / ws,
             ax, ay, bx, by, cx, cy);
    end else if (kind < 90) begin
      // on or next to edge AB
      w1 = $urandom_range(0, 16);
      q = mk(ax + (bx - ax) * w1 / 16 + $urandom_range(0, 2) - 1,
             ay + (by - ay) * w1 / 16 + $urandom_range(0, 2) - 1,
             ax, ay, bx, by, cx, cy);
    end else begin
      q = mk(ox + $urandom_range(0, 12000) - 6000, oy + $urandom_range(0, 12000) - 6000,
             ax, ay, bx, by, cx, cy);
    end
    return q;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || inside_q.size() != 0 || start) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tol_shadow  = val;
  endtask

  initial begin
    logic [TOL_W-1:0] tol_plan[5];
    query_t q;
    n_errors = 0; n_accepted = 0;
    tol_shadow = TOL_RESET;
    rst = 1'b1; start = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    {point_x, point_y, corner_a_x, corner_a_y} = '0;
    {corner_b_x, corner_b_y, corner_c_x, corner_c_y} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed set, at reset tolerance
    pending_q.push_back(mk(256, 256, 0, 0, 1024, 0, 0, 1024));        // plainly inside
    pending_q.push_back(mk(2048, 2048, 0, 0, 1024, 0, 0, 1024));      // plainly outside
    pending_q.push_back(mk(0, 0, 0, 0, 1024, 0, 0, 1024));            // on a corner
    pending_q.push_back(mk(512, 0, 0, 0, 1024, 0, 0, 1024));          // on an edge
    pending_q.push_back(mk(512, -1, 0, 0, 1024, 0, 0, 1024));         // one LSB off edge
    pending_q.push_back(mk(5, 5, 5, 5, 5, 5, 5, 5));                  // all points equal
    pending_q.push_back(mk(6, 5, 5, 5, 5, 5, 5, 5));                  // point off a dot
    pending_q.push_back(mk(200, 200, 0, 0, 400, 400, 800, 800));      // flat, on segment
    pending_q.push_back(mk(200, 201, 0, 0, 400, 400, 800, 800));      // flat, just off
    pending_q.push_back(mk(900, 900, 0, 0, 400, 400, 800, 800));      // flat, past end
    pending_q.push_back(mk(300, 0, 0, 0, 1024, 0, 1024, 0));          // two corners equal
    pending_q.push_back(mk(0, 0, -32768, -32768, 32767, -32768, 0, 32767));
    pending_q.push_back(mk(32767, 32767, -32768, -32768, 32767, -32768, 0, 32767));
    pending_q.push_back(mk(-32768, 32767, -32768, -32768, 32767, 32767, -32768, 32767));
    pending_q.push_back(mk(32767, -32768, -32768, 32767, 32767, -32768, -32768, -32768));
    pending_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_q.push_back(mk(0, 0, 32767, 32767, -32768, -32768, 32767, -32768));
    pending_q.push_back(mk(-1, -1, -256, 0, 0, -256, 256, 256));
    q = mk(100, 50, 0, 0, 200, 0, 100, 200);
    q.drain_first = 1'b1;                       // pause until pipe empties
    pending_q.push_back(q);
    pending_q.push_back(mk(100, 50, 0, 0, 200, 0, 100, 200));

    // tolerance sweep: reset value, zero, max, random, default again
    tol_plan = '{TOL_RESET, 16'd0, 16'hFFFF, 16'($urandom), 16'd66};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_tolerance(tol_plan[ph]);
        // near-miss flat cases are where tolerance matters
        pending_q.push_back(mk(200, 201, 0, 0, 400, 400, 800, 800));
        pending_q.push_back(mk(512, -1, 0, 0, 1024, 0, 0, 1024));
      end
      for (int i = 0; i < ITEMS_PER_PASS; i++) begin
        q = random_query();
        q.drain_first = (i == ITEMS_PER_PASS / 2);
        pending_q.push_back(q);
      end
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("point_in_triangle_area_test regression: pass");
    end else begin
      $display("point_in_triangle_area_test regression: fail");
    end
    $finish;
  end

endmodule
